/* rtl/v3n_pkg.sv */
// Shared widths and constants for the 3D vector normalise pipeline.
package v3n_pkg;

  localparam int COMP_W   = 16;              // input component width, Q4.12
  localparam int NLANE    = 3;               // x, y, z
  localparam int SQ_W     = 2 * COMP_W - 1;  // one square, (-32768)^2 needs 31 bits
  localparam int SUM_W    = SQ_W + 1;        // sum of three squares
  localparam int RSH      = 16;              // S is scaled by 2^RSH before the root
  localparam int RAD_W    = SUM_W + RSH;     // radicand width
  localparam int ROOT_W   = RAD_W / 2;       // root width, Q16.8 length
  localparam int MAG_W    = ROOT_W - RSH / 2; // floor(sqrt(S)) width
  localparam int DIV_SH   = 22;              // numerator scale of the unit quotient
  localparam int QUO_W    = 16;              // quotient bits resolved
  localparam int NUM_W    = COMP_W + DIV_SH; // numerator width
  localparam int REM_W    = NUM_W + 2;       // remainder width in the divider
  localparam int ISQ_SIDE_W = NLANE * COMP_W + 1;
  localparam int DIV_SIDE_W = MAG_W + 1;

  localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(16384);

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [COMP_W-1:0]        cmag_t;
  typedef logic [QUO_W-1:0]         quo_t;

endpackage

/* rtl/v3n_sumsq.sv */
// Input register, three squares and their sum, one stage each.
module v3n_sumsq (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  v3n_pkg::comp_t                        in_comp [v3n_pkg::NLANE],
  output logic                                  out_valid,
  output logic [v3n_pkg::SUM_W-1:0]             out_sum,
  output v3n_pkg::comp_t                        out_comp [v3n_pkg::NLANE]
);
  import v3n_pkg::*;

  logic              v1_r, v2_r, v3_r;
  comp_t             c1_r [NLANE];
  comp_t             c2_r [NLANE];
  comp_t             c3_r [NLANE];
  logic [SQ_W-1:0]   sq_r [NLANE];
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   prod [NLANE];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // squares, signed operands widened to the square width
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      prod[i] = c1_r[i] * c1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= in_comp;
      c2_r  <= c1_r;
      c3_r  <= c2_r;
      for (int i = 0; i < NLANE; i++) begin
        sq_r[i] <= prod[i];
      end
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  assign out_valid = v3_r;
  assign out_sum   = sum_r;
  assign out_comp  = c3_r;

endmodule

/* rtl/v3n_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module v3n_isqrt #(
  parameter int SW = v3n_pkg::ISQ_SIDE_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [v3n_pkg::RAD_W-1:0]     in_rad,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic [v3n_pkg::ROOT_W-1:0]    out_root,
  output logic [SW-1:0]                 out_side
);
  import v3n_pkg::*;

  localparam int N  = ROOT_W;
  localparam int TW = RAD_W + 2;

  logic [N-1:0]      vld_r;
  logic [RAD_W-1:0]  rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [SW-1:0]     side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic              cur_v;
    logic [RAD_W-1:0]  cur_rem;
    logic [N-1:0]      cur_root;
    logic [SW-1:0]     cur_side;
    logic [TW-1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = in_rad;
      assign cur_root = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_v    = vld_r[k-1];
      assign cur_rem  = rem_r[k-1];
      assign cur_root = root_r[k-1];
      assign cur_side = side_r[k-1];
    end

    // trial = (2*root + 2^B) * 2^B
    assign trial = (TW'(cur_root) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = TW'(cur_rem) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? cur_rem - trial[RAD_W-1:0] : cur_rem;
        root_r[k] <= take ? (cur_root | (N'(1) << B)) : cur_root;
        side_r[k] <= cur_side;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

/* rtl/v3n_divide.sv */
// Three-lane pipelined restoring divider, one quotient bit per stage.
module v3n_divide #(
  parameter int SW = v3n_pkg::DIV_SIDE_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [v3n_pkg::ROOT_W-1:0]    in_root,
  input  v3n_pkg::cmag_t                in_mag [v3n_pkg::NLANE],
  input  logic [v3n_pkg::NLANE-1:0]     in_neg,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output v3n_pkg::quo_t                 out_quo [v3n_pkg::NLANE],
  output logic [v3n_pkg::NLANE-1:0]     out_neg,
  output logic [SW-1:0]                 out_side
);
  import v3n_pkg::*;

  localparam int N = QUO_W;

  logic [N-1:0]      vld_r;
  logic [REM_W-1:0]  rem_r  [N][NLANE];
  quo_t              quo_r  [N][NLANE];
  logic [ROOT_W-1:0] root_r [N];
  logic [NLANE-1:0]  neg_r  [N];
  logic [SW-1:0]     side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic              cur_v;
    logic [ROOT_W-1:0] cur_root;
    logic [NLANE-1:0]  cur_neg;
    logic [SW-1:0]     cur_side;
    logic [REM_W-1:0]  cur_rem [NLANE];
    quo_t              cur_quo [NLANE];
    logic [REM_W-1:0]  dsh;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_root = in_root;
      assign cur_neg  = in_neg;
      assign cur_side = in_side;
      for (genvar l = 0; l < NLANE; l++) begin : g_ld
        assign cur_rem[l] = REM_W'({in_mag[l], {DIV_SH{1'b0}}});
        assign cur_quo[l] = '0;
      end
    end else begin : g_next
      assign cur_v    = vld_r[k-1];
      assign cur_root = root_r[k-1];
      assign cur_neg  = neg_r[k-1];
      assign cur_side = side_r[k-1];
      assign cur_rem  = rem_r[k-1];
      assign cur_quo  = quo_r[k-1];
    end

    assign dsh = REM_W'(cur_root) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= cur_v;
      end
    end

    // trial subtract per lane
    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= cur_root;
        neg_r[k]  <= cur_neg;
        side_r[k] <= cur_side;
        for (int l = 0; l < NLANE; l++) begin
          if (cur_rem[l] >= dsh) begin
            rem_r[k][l] <= cur_rem[l] - dsh;
            quo_r[k][l] <= cur_quo[l] | (QUO_W'(1) << B);
          end else begin
            rem_r[k][l] <= cur_rem[l];
            quo_r[k][l] <= cur_quo[l];
          end
        end
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_neg   = neg_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

/* rtl/vector3_normalize.sv */
// Top level of the 3D vector normalise pipeline.
// Takes one Q4.12 vector a clock and gives its floor length and Q1.14 unit vector
// through the squares-and-sum stages, the bit-per-stage square root, the
// bit-per-stage divider and 1 output register. The pipeline moves as one
// whole; it holds only while a beat sits in the output register and out_stall
// is high, and in_stall then follows it in the same cycle.
// A zero vector gives zero components and zero_length set.
module vector3_normalize (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  v3n_pkg::comp_t      in_vec_x,
  input  v3n_pkg::comp_t      in_vec_y,
  input  v3n_pkg::comp_t      in_vec_z,
  output logic                out_valid,
  input  logic                out_stall,
  output v3n_pkg::comp_t      out_unit_x,
  output v3n_pkg::comp_t      out_unit_y,
  output v3n_pkg::comp_t      out_unit_z,
  output logic [15:0]         out_magnitude,
  output logic                out_zero_length
);
  import v3n_pkg::*;

  logic              en;
  comp_t             in_comp [NLANE];
  logic              ss_v;
  logic [SUM_W-1:0]  ss_sum;
  comp_t             ss_comp [NLANE];
  logic [ISQ_SIDE_W-1:0] sq_side_in, sq_side;
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  cmag_t             dv_mag [NLANE];
  logic [NLANE-1:0]  dv_neg_in;
  logic              dv_v;
  quo_t              dv_quo [NLANE];
  logic [NLANE-1:0]  dv_neg;
  logic [DIV_SIDE_W-1:0] dv_side;
  comp_t             unit_nxt [NLANE];
  logic              out_valid_r;
  comp_t             unit_r [NLANE];
  logic [MAG_W-1:0]  mag_r;
  logic              zero_r;

  // whole pipeline advances unless the output beat is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign in_comp[0] = in_vec_x;
  assign in_comp[1] = in_vec_y;
  assign in_comp[2] = in_vec_z;

  v3n_sumsq u_sumsq (
    .clk, .rst_n, .en,
    .in_valid  (in_valid),
    .in_comp   (in_comp),
    .out_valid (ss_v),
    .out_sum   (ss_sum),
    .out_comp  (ss_comp)
  );

  // side data: zero flag and the three components
  assign sq_side_in = {(ss_sum == '0), ss_comp[0], ss_comp[1], ss_comp[2]};

  v3n_isqrt #(.SW(ISQ_SIDE_W)) u_isqrt (
    .clk, .rst_n, .en,
    .in_valid  (ss_v),
    .in_rad    ({ss_sum, {RSH{1'b0}}}),
    .in_side   (sq_side_in),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // sign and magnitude per lane
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      dv_neg_in[l] = sq_side[(NLANE-l)*COMP_W-1];
      dv_mag[l]    = dv_neg_in[l] ? cmag_t'(-sq_side[(NLANE-l)*COMP_W-1 -: COMP_W])
                                  : sq_side[(NLANE-l)*COMP_W-1 -: COMP_W];
    end
  end

  v3n_divide #(.SW(DIV_SIDE_W)) u_divide (
    .clk, .rst_n, .en,
    .in_valid  (sq_v),
    .in_root   (sq_root),
    .in_mag    (dv_mag),
    .in_neg    (dv_neg_in),
    .in_side   ({sq_side[ISQ_SIDE_W-1], sq_root[ROOT_W-1 -: MAG_W]}),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_neg   (dv_neg),
    .out_side  (dv_side)
  );

  // clamp, restore sign, force zero for a zero vector
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      quo_t q;
      q = (dv_quo[l] > UNIT_ONE) ? UNIT_ONE : dv_quo[l];
      if (dv_side[DIV_SIDE_W-1]) begin
        unit_nxt[l] = '0;
      end else if (dv_neg[l]) begin
        unit_nxt[l] = comp_t'(-q);
      end else begin
        unit_nxt[l] = comp_t'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
      mag_r  <= dv_side[MAG_W-1:0];
      zero_r <= dv_side[DIV_SIDE_W-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = unit_r[0];
  assign out_unit_y      = unit_r[1];
  assign out_unit_z      = unit_r[2];
  assign out_magnitude   = mag_r;
  assign out_zero_length = zero_r;

`ifndef ASSERT_OFF
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0 && out_magnitude == '0)
    else $error("zero vector gave non-zero result");

  a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_length |-> out_magnitude != '0 ||
      out_unit_x != '0 || out_unit_y != '0 || out_unit_z != '0)
    else $error("non-zero vector gave all-zero result");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unit_x <= 16'sd16384 && out_unit_x >= -16'sd16384 &&
      out_unit_y <= 16'sd16384 && out_unit_y >= -16'sd16384 &&
      out_unit_z <= 16'sd16384 && out_unit_z >= -16'sd16384)
    else $error("unit component out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(mag_r) && $stable(zero_r))
    else $error("held output beat changed");
`endif

endmodule
